>>> src/hsvrgb_pkg.sv
package hsvrgb_pkg;

   // Command codes carried in the cmd field of an input item.
   localparam logic [1:0] CMD_HSV_TO_RGB = 2'd0;
   localparam logic [1:0] CMD_RGB_TO_HSV = 2'd1;
   localparam logic [1:0] CMD_PALETTE    = 2'd2;
   localparam logic [1:0] CMD_RESERVED   = 2'd3;

   // Shared divider geometry: a 16-bit dividend, a 9-bit divisor, one quotient bit per stage.
   localparam int DIVIDEND_W = 16;
   localparam int DIVISOR_W  = 9;
   localparam int QUOT_W     = 9;

   // Cycles from an accepted item to its result strobe.
   localparam int LATENCY = 12 + QUOT_W;

   typedef struct packed {
      logic [1:0] cmd;
      logic [8:0] hue_in;
      logic [7:0] sat_in;
      logic [7:0] val_in;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [8:0] color_count;
      logic [8:0] base_hue;
      logic [8:0] color_index;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [8:0] hue_out;
      logic [7:0] sat_out;
      logic [7:0] val_out;
      logic       index_error;
   } rsp_type;

endpackage

>>> src/hsvrgb_divider.sv
module hsvrgb_divider import hsvrgb_pkg::*; (
   input  logic                  clock,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [QUOT_W-1:0]     quotient
);

   localparam int TRIAL_W = DIVISOR_W + QUOT_W;

   logic [DIVIDEND_W-1:0] rem_ff [QUOT_W];
   logic [DIVISOR_W-1:0]  dsr_ff [QUOT_W];
   logic [QUOT_W-1:0]     quo_ff [QUOT_W];

   // Restoring division, one quotient bit per stage, most significant bit first.
   for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
      localparam int BIT = QUOT_W - 1 - i;
      logic [DIVIDEND_W-1:0] rem_prev;
      logic [DIVISOR_W-1:0]  dsr_prev;
      logic [QUOT_W-1:0]     quo_prev;
      logic [TRIAL_W-1:0]    trial;
      logic                  fits;

      if (i == 0) begin : g_first
         assign rem_prev = dividend;
         assign dsr_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign dsr_prev = dsr_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      assign trial = {{QUOT_W{1'b0}}, dsr_prev} << BIT;
      assign fits  = ({{(TRIAL_W-DIVIDEND_W){1'b0}}, rem_prev} >= trial);

      always_ff @(posedge clock) begin
         dsr_ff[i] <= dsr_prev;
         if (fits) begin
            rem_ff[i] <= rem_prev - trial[DIVIDEND_W-1:0];
            quo_ff[i] <= quo_prev | (QUOT_W'(1) << BIT);
         end else begin
            rem_ff[i] <= rem_prev;
            quo_ff[i] <= quo_prev;
         end
      end
   end

   assign quotient = quo_ff[QUOT_W-1];

endmodule

>>> src/hsv_rgb_color_converter.sv
// Channel   Ports                      Handshake
// input     start, busy, req_item      item taken when start is high and busy is low
// result    rsp_valid, rsp_item        strobe for one cycle, always taken
//
// One item can enter every cycle.
// The latency is set by the nine-stage restoring divider pipeline plus the
// front-end and the hue, scaling and rescaling stages around it.
// Synchronous reset clears the valid bits; busy is high only during reset.
// Nothing in the pipeline ever stalls, since the receiver cannot hold results off.
module hsv_rgb_color_converter import hsvrgb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam logic [14:0] RECIP_45 = 15'd23302;
   localparam logic [14:0] RECIP_59 = 15'd17773;

   typedef struct packed {
      req_type     req;
      logic [7:0]  mx;
      logic [7:0]  mn;
      logic [8:0]  delta;
      logic [7:0]  sat_c;
      logic [8:0]  hue_c;
      logic [17:0] prod;
      logic [8:0]  quo;
      logic [9:0]  hsum;
      logic [8:0]  h;
      logic [7:0]  s;
      logic [7:0]  v;
      logic [2:0]  sext;
      logic [5:0]  frac;
      logic [13:0] sf;
      logic [13:0] sg;
      logic [15:0] p1prod;
      logic [7:0]  q2;
      logic [7:0]  q3;
      logic [15:0] p2prod;
      logic [15:0] p3prod;
   } work_type;

   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] y;
      y = 17'(x) + 17'(x[15:8]) + 17'd1;
      return y[15:8];
   endfunction

   logic [LATENCY-1:0] valid_ff;
   work_type s0_ff, s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff, s8_ff, s9_ff, s10_ff;
   work_type s0_in, s1_in, s3_in, s4_in, s5_in, s6_in, s7_in, s8_in, s9_in, s10_in;
   work_type dl_ff [QUOT_W];
   rsp_type  rsp_item_ff, rsp_item_in;

   logic [DIVIDEND_W-1:0] sat_dvd_ff, r_dvd_ff, g_dvd_ff, b_dvd_ff, pal_dvd_ff;
   logic [DIVIDEND_W-1:0] sat_dvd_in, r_dvd_in, g_dvd_in, b_dvd_in, pal_dvd_in;
   logic [DIVISOR_W-1:0]  mx_dsr_ff, spr_dsr_ff, cnt_dsr_ff;
   logic [DIVISOR_W-1:0]  mx_dsr_in, spr_dsr_in, cnt_dsr_in;
   logic [QUOT_W-1:0]     q_sat, q_r, q_g, q_b, q_pal;
   logic [7:0]            spread;

   assign busy = reset;

   // Input register.
   always_comb begin
      s0_in     = '0;
      s0_in.req = req_item;
   end

   // Largest and smallest color component.
   always_comb begin
      s1_in    = s0_ff;
      s1_in.mx = s0_ff.req.red_in;
      s1_in.mn = s0_ff.req.red_in;
      if (s0_ff.req.green_in > s1_in.mx) s1_in.mx = s0_ff.req.green_in;
      if (s0_ff.req.blue_in > s1_in.mx) s1_in.mx = s0_ff.req.blue_in;
      if (s0_ff.req.green_in < s1_in.mn) s1_in.mn = s0_ff.req.green_in;
      if (s0_ff.req.blue_in < s1_in.mn) s1_in.mn = s0_ff.req.blue_in;
   end

   // Dividends and divisors for the five dividers.
   always_comb begin
      spread     = s1_ff.mx - s1_ff.mn;
      sat_dvd_in = 16'(spread) * 16'd255;
      r_dvd_in   = 16'(s1_ff.mx - s1_ff.req.red_in) * 16'd59;
      g_dvd_in   = 16'(s1_ff.mx - s1_ff.req.green_in) * 16'd59;
      b_dvd_in   = 16'(s1_ff.mx - s1_ff.req.blue_in) * 16'd59;
      pal_dvd_in = 16'd360;
      mx_dsr_in  = 9'(s1_ff.mx);
      spr_dsr_in = 9'(spread);
      cnt_dsr_in = (s1_ff.req.color_count == 9'd0) ? 9'd1 : s1_ff.req.color_count;
   end

   hsvrgb_divider u_div_sat (.clock(clock), .dividend(sat_dvd_ff), .divisor(mx_dsr_ff),
                             .quotient(q_sat));
   hsvrgb_divider u_div_r (.clock(clock), .dividend(r_dvd_ff), .divisor(spr_dsr_ff),
                           .quotient(q_r));
   hsvrgb_divider u_div_g (.clock(clock), .dividend(g_dvd_ff), .divisor(spr_dsr_ff),
                           .quotient(q_g));
   hsvrgb_divider u_div_b (.clock(clock), .dividend(b_dvd_ff), .divisor(spr_dsr_ff),
                           .quotient(q_b));
   hsvrgb_divider u_div_pal (.clock(clock), .dividend(pal_dvd_ff), .divisor(cnt_dsr_ff),
                             .quotient(q_pal));

   // Converted hue and saturation, palette spacing and index times spacing.
   always_comb begin
      work_type w;
      w     = dl_ff[QUOT_W-1];
      s3_in = w;
      s3_in.sat_c = (w.mx == 8'd0) ? 8'd0 : q_sat[7:0];
      if (w.mx <= w.mn) begin
         s3_in.hue_c = 9'd0;
      end else if (w.mx == w.req.red_in && w.mn == w.req.green_in) begin
         s3_in.hue_c = 9'd300 + 9'(q_b[5:0]);
      end else if (w.mx == w.req.red_in) begin
         s3_in.hue_c = 9'd60 - 9'(q_g[5:0]);
      end else if (w.mx == w.req.green_in && w.mn == w.req.blue_in) begin
         s3_in.hue_c = 9'd60 + 9'(q_r[5:0]);
      end else if (w.mx == w.req.green_in) begin
         s3_in.hue_c = 9'd180 - 9'(q_b[5:0]);
      end else if (w.mn == w.req.red_in) begin
         s3_in.hue_c = 9'd180 + 9'(q_g[5:0]);
      end else begin
         s3_in.hue_c = 9'd300 - 9'(q_r[5:0]);
      end
      s3_in.delta = (w.req.color_count == 9'd0) ? 9'd360 : q_pal;
      s3_in.prod  = 18'(w.req.color_index) * 18'(s3_in.delta);
   end

   // Quotient of the product by 360, as (prod / 8) / 45 through a reciprocal.
   always_comb begin
      logic [29:0] m;
      s4_in     = s3_ff;
      m         = 30'(s3_ff.prod[17:3]) * 30'(RECIP_45);
      s4_in.quo = m[28:20];
   end

   // Remainder of the product, added to the starting hue.
   always_comb begin
      logic [17:0] rem;
      s5_in      = s4_ff;
      rem        = s4_ff.prod - 18'(s4_ff.quo) * 18'd360;
      s5_in.hsum = 10'(s4_ff.req.base_hue) + 10'(rem[8:0]);
   end

   // Hue, saturation and value that feed the color stages, per command.
   always_comb begin
      s6_in = s5_ff;
      s6_in.h = 9'd0;
      s6_in.s = 8'd0;
      s6_in.v = 8'd0;
      case (s5_ff.req.cmd)
         CMD_HSV_TO_RGB: begin
            s6_in.h = (s5_ff.req.hue_in >= 9'd360) ? s5_ff.req.hue_in - 9'd360
                                                   : s5_ff.req.hue_in;
            s6_in.s = s5_ff.req.sat_in;
            s6_in.v = s5_ff.req.val_in;
         end
         CMD_RGB_TO_HSV: begin
            s6_in.h = s5_ff.hue_c;
            s6_in.s = s5_ff.sat_c;
            s6_in.v = s5_ff.mx;
         end
         CMD_PALETTE: begin
            if (s5_ff.hsum >= 10'd720) s6_in.h = 9'(s5_ff.hsum - 10'd720);
            else if (s5_ff.hsum >= 10'd360) s6_in.h = 9'(s5_ff.hsum - 10'd360);
            else s6_in.h = s5_ff.hsum[8:0];
            s6_in.s = 8'd255;
            s6_in.v = 8'd255;
         end
         default: begin
            s6_in.h = 9'd0;
         end
      endcase
   end

   // Sextant of the hue and the fraction within it.
   always_comb begin
      s7_in = s6_ff;
      if (s6_ff.h < 9'd60) s7_in.sext = 3'd0;
      else if (s6_ff.h < 9'd120) s7_in.sext = 3'd1;
      else if (s6_ff.h < 9'd180) s7_in.sext = 3'd2;
      else if (s6_ff.h < 9'd240) s7_in.sext = 3'd3;
      else if (s6_ff.h < 9'd300) s7_in.sext = 3'd4;
      else s7_in.sext = 3'd5;
      s7_in.frac = 6'(s6_ff.h - 9'(s7_in.sext) * 9'd60);
   end

   // Saturation scaled by the fraction and by its complement, and the value by the complemented saturation.
   always_comb begin
      s8_in        = s7_ff;
      s8_in.sf     = 14'(s7_ff.s) * 14'(s7_ff.frac);
      s8_in.sg     = 14'(s7_ff.s) * 14'(6'd59 - s7_ff.frac);
      s8_in.p1prod = 16'(8'd255 - s7_ff.s) * 16'(s7_ff.v);
   end

   // Division of both scaled terms by 59.
   always_comb begin
      logic [28:0] m2;
      logic [28:0] m3;
      s9_in    = s8_ff;
      m2       = 29'(s8_ff.sf) * 29'(RECIP_59);
      m3       = 29'(s8_ff.sg) * 29'(RECIP_59);
      s9_in.q2 = m2[27:20];
      s9_in.q3 = m3[27:20];
   end

   // Products of the value with the complemented terms.
   always_comb begin
      s10_in        = s9_ff;
      s10_in.p2prod = 16'(8'd255 - s9_ff.q2) * 16'(s9_ff.v);
      s10_in.p3prod = 16'(8'd255 - s9_ff.q3) * 16'(s9_ff.v);
   end

   // Division by 255, channel selection and result assembly.
   always_comb begin
      logic [7:0] p1;
      logic [7:0] p2;
      logic [7:0] p3;
      logic [7:0] vv;
      p1 = div255(s10_ff.p1prod);
      p2 = div255(s10_ff.p2prod);
      p3 = div255(s10_ff.p3prod);
      vv = s10_ff.v;
      rsp_item_in = '0;
      case (s10_ff.sext)
         3'd0: begin
            rsp_item_in.red_out = vv; rsp_item_in.green_out = p3; rsp_item_in.blue_out = p1;
         end
         3'd1: begin
            rsp_item_in.red_out = p2; rsp_item_in.green_out = vv; rsp_item_in.blue_out = p1;
         end
         3'd2: begin
            rsp_item_in.red_out = p1; rsp_item_in.green_out = vv; rsp_item_in.blue_out = p3;
         end
         3'd3: begin
            rsp_item_in.red_out = p1; rsp_item_in.green_out = p2; rsp_item_in.blue_out = vv;
         end
         3'd4: begin
            rsp_item_in.red_out = p3; rsp_item_in.green_out = p1; rsp_item_in.blue_out = vv;
         end
         default: begin
            rsp_item_in.red_out = vv; rsp_item_in.green_out = p1; rsp_item_in.blue_out = p2;
         end
      endcase
      rsp_item_in.hue_out = s10_ff.h;
      rsp_item_in.sat_out = s10_ff.s;
      rsp_item_in.val_out = s10_ff.v;
      case (s10_ff.req.cmd)
         CMD_HSV_TO_RGB: begin
            rsp_item_in.index_error = 1'b0;
         end
         CMD_RGB_TO_HSV: begin
            rsp_item_in.red_out   = s10_ff.req.red_in;
            rsp_item_in.green_out = s10_ff.req.green_in;
            rsp_item_in.blue_out  = s10_ff.req.blue_in;
         end
         CMD_PALETTE: begin
            rsp_item_in.index_error = (s10_ff.req.color_index >= s10_ff.req.color_count);
         end
         default: begin
            rsp_item_in = '0;
         end
      endcase
   end

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LATENCY-2:0], start};
      end
   end

   // Payload stage registers.
   always_ff @(posedge clock) begin
      s0_ff      <= s0_in;
      s1_ff      <= s1_in;
      s2_ff      <= s1_ff;
      sat_dvd_ff <= sat_dvd_in;
      r_dvd_ff   <= r_dvd_in;
      g_dvd_ff   <= g_dvd_in;
      b_dvd_ff   <= b_dvd_in;
      pal_dvd_ff <= pal_dvd_in;
      mx_dsr_ff  <= mx_dsr_in;
      spr_dsr_ff <= spr_dsr_in;
      cnt_dsr_ff <= cnt_dsr_in;
      dl_ff[0]   <= s2_ff;
      for (int i = 1; i < QUOT_W; i++) begin
         dl_ff[i] <= dl_ff[i-1];
      end
      s3_ff       <= s3_in;
      s4_ff       <= s4_in;
      s5_ff       <= s5_in;
      s6_ff       <= s6_in;
      s7_ff       <= s7_in;
      s8_ff       <= s8_in;
      s9_ff       <= s9_in;
      s10_ff      <= s10_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = valid_ff[LATENCY-1];
   assign rsp_item  = rsp_item_ff;

endmodule

>>> src/hsvrgb_checker.sv
module hsvrgb_checker import hsvrgb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // The block only holds off items during reset.
   a_no_busy: assert property (@(posedge clock) !reset |-> !busy)
      else $error("busy outside reset");

   // Every result strobe answers an item taken earlier.
   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching item");

   // Hue results always lie within one turn.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.hue_out < 9'd360)
      else $error("hue out of range");

   // A reserved command gives an all-zero result.
   a_reserved_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(start && !busy && req_item.cmd == CMD_RESERVED, LATENCY)
      |-> rsp_item == '0)
      else $error("reserved command result not zero");

   // Palette colors are fully saturated at full value.
   a_palette_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(start && !busy && req_item.cmd == CMD_PALETTE, LATENCY)
      |-> rsp_item.sat_out == 8'd255 && rsp_item.val_out == 8'd255)
      else $error("palette color not fully saturated");

endmodule

bind hsv_rgb_color_converter hsvrgb_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item)
);
